/* rtl/prtkr_pkg.sv */
// ----------------------------------------------------------------------------
// prtkr_pkg
// Shared types and codes for the packed record table with keyed remove.
// ----------------------------------------------------------------------------
package prtkr_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 128;
  localparam int unsigned KEY_W           = 16;
  localparam int unsigned NAME_W          = 32;
  localparam int unsigned COIN_W          = 32;
  localparam int unsigned FILL_W          = 8;
  localparam int unsigned CODE_W          = 2;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [CODE_W-1:0] {
    RC_OK        = 2'd0,
    RC_NOT_FOUND = 2'd1,
    RC_FULL      = 2'd2
  } result_code_t;

  typedef struct packed {
    logic [KEY_W-1:0]         key;
    logic [NAME_W-1:0]        name_handle;
    logic signed [COIN_W-1:0] coins;
    logic                     active_flag;
  } record_t;

endpackage

/* rtl/packed_record_table_keyed_remove_unit.sv */
// ----------------------------------------------------------------------------
// packed_record_table_keyed_remove_unit
// Packed record table: append at the fill position, remove the first record
// with a matching key and shift later records down one place.
// ----------------------------------------------------------------------------
// Append, full and remove on an empty table: the result strobe follows the
// transaction in the next cycle; busy stays low, so one such transaction per cycle.
// Remove: one memory read per cycle sweeps the table and each shift write
// follows its read in the next cycle; busy stays high until the result
// strobe. Results cannot be stalled.
// Synchronous reset empties the table; record contents are left as they are.
module packed_record_table_keyed_remove_unit #(
  parameter int unsigned TABLE_DEPTH = prtkr_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_operation,
  input  logic [prtkr_pkg::KEY_W-1:0]         in_key,
  input  logic [prtkr_pkg::NAME_W-1:0]        in_name_handle,
  input  logic signed [prtkr_pkg::COIN_W-1:0] in_coins,
  input  logic                                in_active_flag,
  output logic                                out_valid,
  output logic [prtkr_pkg::CODE_W-1:0]        out_result_code,
  output logic [prtkr_pkg::FILL_W-1:0]        out_fill_count
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_SHIFT  = 3'b100
  } state_t;

  state_t                            state_r, state_nxt;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [CW-1:0]                     rp_r, rp_nxt;
  logic                              rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]                     rd_addr_r, rd_addr_nxt;
  logic [prtkr_pkg::KEY_W-1:0]       key_r, key_nxt;
  logic                              out_valid_r, out_valid_nxt;
  prtkr_pkg::result_code_t           code_r, code_nxt;
  logic [prtkr_pkg::FILL_W-1:0]      fill_r, fill_nxt;

  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  prtkr_pkg::record_t                mem_wdata;
  logic                              mem_re;
  logic [AW-1:0]                     mem_raddr;
  prtkr_pkg::record_t                mem_rdata;
  prtkr_pkg::record_t                in_rec;
  logic                              last_rd;

  assign in_rec.key         = in_key;
  assign in_rec.name_handle = in_name_handle;
  assign in_rec.coins       = in_coins;
  assign in_rec.active_flag = in_active_flag;

  assign last_rd = (CW'(rd_addr_r) == (count_r - ONE_C));

  prtkr_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rp_nxt        = rp_r;
    rd_vld_nxt    = 1'b0;
    rd_addr_nxt   = rd_addr_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    code_nxt      = code_r;
    fill_nxt      = fill_r;
    mem_we        = 1'b0;
    mem_waddr     = count_r[AW-1:0];
    mem_wdata     = in_rec;
    mem_re        = 1'b0;
    mem_raddr     = rp_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt = in_key;
          if (in_operation == prtkr_pkg::OP_APPEND) begin
            out_valid_nxt = 1'b1;
            if (count_r == DEPTH_C) begin
              code_nxt = prtkr_pkg::RC_FULL;
              fill_nxt = prtkr_pkg::FILL_W'(count_r);
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + ONE_C;
              code_nxt  = prtkr_pkg::RC_OK;
              fill_nxt  = prtkr_pkg::FILL_W'(count_r + ONE_C);
            end
          end else if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            code_nxt      = prtkr_pkg::RC_NOT_FOUND;
            fill_nxt      = prtkr_pkg::FILL_W'(count_r);
          end else begin
            rp_nxt    = '0;
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH, ST_SHIFT: begin
        if (rp_r < count_r) begin
          mem_re      = 1'b1;
          rp_nxt      = rp_r + ONE_C;
          rd_vld_nxt  = 1'b1;
          rd_addr_nxt = rp_r[AW-1:0];
        end
        if (rd_vld_r) begin
          if (state_r == ST_SHIFT) begin
            mem_we    = 1'b1;
            mem_waddr = rd_addr_r - AW'(1);
            mem_wdata = mem_rdata;
          end
          if (state_r == ST_SEARCH && mem_rdata.key == key_r && !last_rd) begin
            state_nxt = ST_SHIFT;
          end else if (last_rd) begin
            out_valid_nxt = 1'b1;
            rd_vld_nxt    = 1'b0;
            state_nxt     = ST_IDLE;
            if (state_r == ST_SHIFT || mem_rdata.key == key_r) begin
              count_nxt = count_r - ONE_C;
              code_nxt  = prtkr_pkg::RC_OK;
              fill_nxt  = prtkr_pkg::FILL_W'(count_r - ONE_C);
            end else begin
              code_nxt  = prtkr_pkg::RC_NOT_FOUND;
              fill_nxt  = prtkr_pkg::FILL_W'(count_r);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rp_r        <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rp_r        <= rp_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    key_r     <= key_nxt;
    code_r    <= code_nxt;
    fill_r    <= fill_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_code = code_r;
  assign out_fill_count  = fill_r;

endmodule

/* rtl/prtkr_mem.sv */
// ----------------------------------------------------------------------------
// prtkr_mem
// Record memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module prtkr_mem #(
  parameter int unsigned TABLE_DEPTH = prtkr_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  prtkr_pkg::record_t wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output prtkr_pkg::record_t rd_data
);

  prtkr_pkg::record_t mem [TABLE_DEPTH];
  prtkr_pkg::record_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packed record table with keyed remove. Plain
// tasks drive append and remove transactions with random gaps. A tracker
// class keeps its own packed copy of the records. It predicts the code and
// fill count of every transaction and compares each result strobe against
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned DEPTH       = prtkr_pkg::TABLE_DEPTH_DEF;
  localparam int unsigned STALL_LIMIT = 4 * DEPTH + 1000;
  localparam int unsigned RAND_ITEMS  = 1950;

  class record_table_tracker;
    prtkr_pkg::record_t                records[$];
    prtkr_pkg::result_code_t           pending_codes[$];
    logic [prtkr_pkg::FILL_W-1:0]      pending_fills[$];
    int unsigned                       depth;
    int unsigned                       fail_count;

    function new(int unsigned d);
      depth      = d;
      fail_count = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      fail_count++;
    endtask

    function int unsigned pending();
      return pending_codes.size();
    endfunction

    function int unsigned fill();
      return records.size();
    endfunction

    function logic [prtkr_pkg::KEY_W-1:0] key_at(int unsigned idx);
      return records[idx].key;
    endfunction

    function void note_transaction(logic op, prtkr_pkg::record_t rec);
      prtkr_pkg::result_code_t code;
      int                      hit;
      hit = -1;
      if (op == prtkr_pkg::OP_APPEND) begin
        if (records.size() >= depth) begin
          code = prtkr_pkg::RC_FULL;
        end else begin
          records.push_back(rec);
          code = prtkr_pkg::RC_OK;
        end
      end else begin
        foreach (records[i]) begin
          if (hit < 0 && records[i].key == rec.key) hit = i;
        end
        if (hit < 0) begin
          code = prtkr_pkg::RC_NOT_FOUND;
        end else begin
          records.delete(hit);
          code = prtkr_pkg::RC_OK;
        end
      end
      pending_codes.push_back(code);
      pending_fills.push_back(prtkr_pkg::FILL_W'(records.size()));
    endfunction

    task check_result(logic [prtkr_pkg::CODE_W-1:0] code,
                      logic [prtkr_pkg::FILL_W-1:0] fill_cnt);
      prtkr_pkg::result_code_t      exp_code;
      logic [prtkr_pkg::FILL_W-1:0] exp_fill;
      if (pending_codes.size() == 0) begin
        report($sformatf("unexpected result code=%0d fill=%0d", code, fill_cnt));
        return;
      end
      exp_code = pending_codes.pop_front();
      exp_fill = pending_fills.pop_front();
      if (code !== exp_code)
        report($sformatf("result_code got %0d want %0d", code, exp_code));
      if (fill_cnt !== exp_fill)
        report($sformatf("fill_count got %0d want %0d", fill_cnt, exp_fill));
    endtask

    task check_drained();
      if (pending_codes.size() != 0)
        report($sformatf("%0d results never arrived", pending_codes.size()));
    endtask
  endclass

  logic                                 clk;
  logic                                 rst_n;
  logic                                 start;
  logic                                 busy;
  logic                                 in_operation;
  logic [prtkr_pkg::KEY_W-1:0]          in_key;
  logic [prtkr_pkg::NAME_W-1:0]         in_name_handle;
  logic signed [prtkr_pkg::COIN_W-1:0]  in_coins;
  logic                                 in_active_flag;
  logic                                 out_valid;
  logic [prtkr_pkg::CODE_W-1:0]         out_result_code;
  logic [prtkr_pkg::FILL_W-1:0]         out_fill_count;

  record_table_tracker tracker;
  int unsigned         idle_pct;
  int unsigned         quiet_cycles;

  packed_record_table_keyed_remove_unit #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_key         (in_key),
    .in_name_handle (in_name_handle),
    .in_coins       (in_coins),
    .in_active_flag (in_active_flag),
    .out_valid      (out_valid),
    .out_result_code(out_result_code),
    .out_fill_count (out_fill_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_result_code, out_fill_count);
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_transaction(logic op, logic [prtkr_pkg::KEY_W-1:0] key,
                                  logic [prtkr_pkg::NAME_W-1:0] name,
                                  logic [prtkr_pkg::COIN_W-1:0] coins, logic flag,
                                  bit drain);
    prtkr_pkg::record_t rec;
    rec.key         = key;
    rec.name_handle = name;
    rec.coins       = coins;
    rec.active_flag = flag;
    @(negedge clk);
    if (drain) begin
      while (tracker.pending() != 0) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_operation   <= op;
    in_key         <= key;
    in_name_handle <= name;
    in_coins       <= coins;
    in_active_flag <= flag;
    do @(posedge clk); while (busy);
    tracker.note_transaction(op, rec);
  endtask

  function automatic logic [prtkr_pkg::KEY_W-1:0] random_key();
    if ($urandom_range(0, 1) == 0) return prtkr_pkg::KEY_W'($urandom_range(0, 15));
    return prtkr_pkg::KEY_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_random(int unsigned append_pct, bit drain);
    logic                        op;
    logic [prtkr_pkg::KEY_W-1:0] key;
    op  = ($urandom_range(0, 99) < append_pct) ? prtkr_pkg::OP_APPEND : prtkr_pkg::OP_REMOVE;
    key = random_key();
    if (op == prtkr_pkg::OP_REMOVE && tracker.fill() != 0 && $urandom_range(0, 9) < 7)
      key = tracker.key_at($urandom_range(0, tracker.fill() - 1));
    send_transaction(op, key, $urandom, $urandom, 1'($urandom_range(0, 1)), drain);
  endtask

  initial begin
    tracker        = new(DEPTH);
    quiet_cycles   = 0;
    idle_pct       = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = prtkr_pkg::OP_APPEND;
    in_key         = '0;
    in_name_handle = '0;
    in_coins       = '0;
    in_active_flag = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // empty table, field extremes, duplicate keys, first/middle/last removal
    send_transaction(prtkr_pkg::OP_REMOVE, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b0);
    send_transaction(prtkr_pkg::OP_APPEND, 16'h0000, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0);
    send_transaction(prtkr_pkg::OP_APPEND, 16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_transaction(prtkr_pkg::OP_APPEND, 16'h1234, 32'hA5A5_5A5A, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_transaction(prtkr_pkg::OP_APPEND, 16'h1234, 32'h5A5A_A5A5, 32'h0000_0000, 1'b0, 1'b0);
    send_transaction(prtkr_pkg::OP_APPEND, 16'h0005, 32'h0000_0001, 32'h0000_0001, 1'b1, 1'b0);
    send_transaction(prtkr_pkg::OP_REMOVE, 16'h1234, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_transaction(prtkr_pkg::OP_REMOVE, 16'h0005, 32'h0, 32'h0, 1'b0, 1'b0);
    send_transaction(prtkr_pkg::OP_REMOVE, 16'h7777, 32'h0, 32'h0, 1'b0, 1'b0);
    send_transaction(prtkr_pkg::OP_REMOVE, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b0);
    send_transaction(prtkr_pkg::OP_REMOVE, 16'h1234, 32'h0, 32'h0, 1'b0, 1'b0);
    send_transaction(prtkr_pkg::OP_REMOVE, 16'hFFFF, 32'h0, 32'h0, 1'b0, 1'b0);
    send_transaction(prtkr_pkg::OP_REMOVE, 16'hFFFF, 32'h0, 32'h0, 1'b0, 1'b0);

    // alternate fill-heavy and drain-heavy stretches so the table hits full
    for (int i = 0; i < RAND_ITEMS; i++) begin
      case ((i / 130) % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 55;
        default: idle_pct = 6;
      endcase
      send_random(((i / 240) % 2 == 0) ? 85 : 35,
                  (i % 500 == 0) || ($urandom_range(0, 149) == 0));
    end

    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (2 * DEPTH + 4) @(posedge clk);
    tracker.check_drained();
    if (tracker.fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
